### hdl/bouncing_ball_step_core_defines.svh
// Assertion macros shared by the bouncing ball step core modules.
// Included by bbs_ctrl and bouncing_ball_step_core; depends on nothing.
`ifndef BOUNCING_BALL_STEP_CORE_DEFINES_SVH
`define BOUNCING_BALL_STEP_CORE_DEFINES_SVH

// Same-cycle implication, held off during reset
`define BBS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset
`define BBS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/bbs_pkg.sv
// Shared types and constants for the bouncing ball step core.
// Used by bbs_boost_unit, bbs_ctrl and bouncing_ball_step_core; no dependencies.
package bbs_pkg;

    // Field widths
    localparam int POS_W      = 21;
    localparam int VEL_W      = 16;
    localparam int GRAV_W     = 8;
    localparam int BOOST_W    = 9;
    localparam int LIM_W      = 15;
    localparam int FIELD_W    = 12;
    localparam int RAD_W      = 8;
    localparam int TDATA_W    = 80;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    // Working velocity width: room for three boost products before the final clamp
    localparam int VW          = 24;
    localparam int BOOST_BITS  = 8;
    localparam int PROD_W      = VW + BOOST_W + 1;

    localparam int POS_MAX = 1048575;
    localparam int POS_MIN = -1048576;

    localparam logic signed [VEL_W-1:0] VEL_RAW_MIN = 16'sh8000;
    localparam logic signed [VEL_W-1:0] VEL_NEG_MAX = -16'sd32767;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRAVITY_STEP = 3'd0,
        CFG_BOOST_FACTOR = 3'd1,
        CFG_SPEED_LIMIT  = 3'd2,
        CFG_FIELD_WIDTH  = 3'd3,
        CFG_FIELD_HEIGHT = 3'd4,
        CFG_RADIUS       = 3'd5
    } bbs_cfg_idx_t;

    // Sequencer states
    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_ADD    = 9'b000000010,
        ST_WALL_R = 9'b000000100,
        ST_WALL_L = 9'b000001000,
        ST_WALL_B = 9'b000010000,
        ST_BOT_X  = 9'b000100000,
        ST_WALL_T = 9'b001000000,
        ST_CLAMP  = 9'b010000000,
        ST_OUT    = 9'b100000000
    } bbs_state_t;

    // Step strobes from the sequencer to the datapath
    typedef struct packed {
        logic load;
        logic add;
        logic wall_right;
        logic wall_left;
        logic wall_bottom;
        logic bottom_x;
        logic wall_top;
        logic vel_clamp;
        logic out_load;
    } bbs_ctrl_t;

endpackage

### hdl/bbs_boost_unit.sv
// Shared boost multiplier: velocity times boost, optional negate, floor shift.
// Depends on bbs_pkg.
module bbs_boost_unit (
    input  logic signed [bbs_pkg::VW-1:0]      vel_in,
    input  logic        [bbs_pkg::BOOST_W-1:0] boost,
    input  logic                               negate,
    output logic signed [bbs_pkg::VW-1:0]      vel_out
);

    logic signed [bbs_pkg::PROD_W-1:0] vel_ext;
    logic signed [bbs_pkg::PROD_W-1:0] boost_ext;
    logic signed [bbs_pkg::PROD_W-1:0] prod;
    logic signed [bbs_pkg::PROD_W-1:0] prod_sgn;
    logic signed [bbs_pkg::PROD_W-1:0] prod_shr;

    // Extend both operands to the product width, boost as a positive value
    assign vel_ext   = bbs_pkg::PROD_W'(vel_in);
    assign boost_ext = {{(bbs_pkg::PROD_W - bbs_pkg::BOOST_W){1'b0}}, boost};

    // Multiply, flip sign on a wall bounce, shift arithmetically (floor)
    assign prod     = vel_ext * boost_ext;
    assign prod_sgn = negate ? -prod : prod;
    assign prod_shr = prod_sgn >>> bbs_pkg::BOOST_BITS;
    assign vel_out  = prod_shr[bbs_pkg::VW-1:0];

endmodule

### hdl/bbs_ctrl.sv
// Step sequencer: walks one tick through add, four wall tests, the bottom horizontal boost and velocity clamp.
// Depends on bbs_pkg and bouncing_ball_step_core_defines.svh.
`include "bouncing_ball_step_core_defines.svh"

module bbs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic              is_load,
    input  logic              out_free,
    output logic              ready,
    output bbs_pkg::bbs_ctrl_t ctl
);

    bbs_pkg::bbs_state_t state_reg;
    bbs_pkg::bbs_state_t state_next;

    // Advance through the fixed step order
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bbs_pkg::ST_IDLE: begin
                if (start) begin
                    state_next = is_load ? bbs_pkg::ST_OUT : bbs_pkg::ST_ADD;
                end
            end
            bbs_pkg::ST_ADD:    state_next = bbs_pkg::ST_WALL_R;
            bbs_pkg::ST_WALL_R: state_next = bbs_pkg::ST_WALL_L;
            bbs_pkg::ST_WALL_L: state_next = bbs_pkg::ST_WALL_B;
            bbs_pkg::ST_WALL_B: state_next = bbs_pkg::ST_BOT_X;
            bbs_pkg::ST_BOT_X:  state_next = bbs_pkg::ST_WALL_T;
            bbs_pkg::ST_WALL_T: state_next = bbs_pkg::ST_CLAMP;
            bbs_pkg::ST_CLAMP:  state_next = bbs_pkg::ST_OUT;
            bbs_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = bbs_pkg::ST_IDLE;
                end
            end
            default:            state_next = bbs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bbs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Decode step strobes
    assign ready           = (state_reg == bbs_pkg::ST_IDLE);
    assign ctl.load        = ready && start && is_load;
    assign ctl.add         = (state_reg == bbs_pkg::ST_ADD);
    assign ctl.wall_right  = (state_reg == bbs_pkg::ST_WALL_R);
    assign ctl.wall_left   = (state_reg == bbs_pkg::ST_WALL_L);
    assign ctl.wall_bottom = (state_reg == bbs_pkg::ST_WALL_B);
    assign ctl.bottom_x    = (state_reg == bbs_pkg::ST_BOT_X);
    assign ctl.wall_top    = (state_reg == bbs_pkg::ST_WALL_T);
    assign ctl.vel_clamp   = (state_reg == bbs_pkg::ST_CLAMP);
    assign ctl.out_load    = (state_reg == bbs_pkg::ST_OUT) && out_free;

    `BBS_ASSERT_NEXT(a_tick_starts_add, aclk, aresetn, ready && start && !is_load, state_reg == bbs_pkg::ST_ADD, "tick item did not enter the add step")
    `BBS_ASSERT_NEXT(a_clamp_then_out, aclk, aresetn, ctl.vel_clamp, state_reg == bbs_pkg::ST_OUT, "velocity clamp not followed by output step")

endmodule

### hdl/bouncing_ball_step_core.sv
// Bouncing ball step core. One item is taken at a time. A load item (tuser high)
// goes from acceptance straight to the output step; a tick item passes through the
// gravity and position add, each of the four wall tests, the horizontal boost
// after a bottom hit and the velocity clamp, with the wall bounces and that boost
// sharing a single boost multiplier. The output step registers the result once the
// result register is free. The next item is taken in the cycle after the result is
// registered, even if that result has not yet been taken; the result register holds
// it until m_tready. Configuration writes apply at once and belong between items.
// Depends on bbs_pkg, bbs_boost_unit, bbs_ctrl and the defines header.
`include "bouncing_ball_step_core_defines.svh"

module bouncing_ball_step_core #(
    parameter int FRAC_BITS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // load_pos_x[20:0], load_pos_y[41:21], load_vel_x[57:42], load_vel_y[73:58], zero pad
    input  logic [bbs_pkg::TDATA_W-1:0]       s_tdata,
    // command: 0 tick, 1 load
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pos_x[20:0], pos_y[41:21], vel_x[57:42], vel_y[73:58], zero pad
    output logic [bbs_pkg::TDATA_W-1:0]       m_tdata,
    input  logic                              cfg_we,
    input  logic [bbs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bbs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CW = (FRAC_BITS + 14 > 26) ? FRAC_BITS + 14 : 26;
    localparam logic signed [CW-1:0] POS_HI = CW'(bbs_pkg::POS_MAX);
    localparam logic signed [CW-1:0] POS_LO = CW'(bbs_pkg::POS_MIN);
    localparam int PAD_W = bbs_pkg::TDATA_W - 2 * bbs_pkg::POS_W - 2 * bbs_pkg::VEL_W;

    // Saturate a wide position to the 21-bit range
    function automatic logic signed [bbs_pkg::POS_W-1:0] sat_pos(
        input logic signed [CW-1:0] v
    );
        logic signed [CW-1:0] c;
        c = (v > POS_HI) ? POS_HI : ((v < POS_LO) ? POS_LO : v);
        return c[bbs_pkg::POS_W-1:0];
    endfunction

    // Configuration registers
    logic [bbs_pkg::GRAV_W-1:0]  gravity_reg;
    logic [bbs_pkg::BOOST_W-1:0] boost_reg;
    logic [bbs_pkg::LIM_W-1:0]   limit_reg;
    logic [bbs_pkg::FIELD_W-1:0] width_reg;
    logic [bbs_pkg::FIELD_W-1:0] height_reg;
    logic [bbs_pkg::RAD_W-1:0]   radius_reg;

    // Ball state
    logic signed [bbs_pkg::POS_W-1:0] pos_x_reg;
    logic signed [bbs_pkg::POS_W-1:0] pos_y_reg;
    logic signed [bbs_pkg::VW-1:0]    vel_x_reg;
    logic signed [bbs_pkg::VW-1:0]    vel_y_reg;
    logic                             bot_hit_reg;

    // Result register
    logic [bbs_pkg::TDATA_W-1:0] m_tdata_reg;
    logic [bbs_pkg::TDATA_W-1:0] m_tdata_next;
    logic                        m_tvalid_reg;

    bbs_pkg::bbs_ctrl_t ctl;
    logic               start;
    logic               out_free;

    logic signed [CW-1:0] x_ext, y_ext, vx_ext, vy_ext, g_ext;
    logic signed [CW-1:0] r_ext, w_ext, h_ext;
    logic signed [CW-1:0] sum_x, sum_y;
    logic                 hit_right, hit_left, hit_bottom, hit_top;
    logic signed [bbs_pkg::POS_W-1:0] clamp_r, clamp_b, clamp_lt;
    logic signed [bbs_pkg::VW-1:0]    g_vel;
    logic signed [bbs_pkg::VW-1:0]    lim_ext, neg_lim;
    logic signed [bbs_pkg::VW-1:0]    vx_cl, vy_cl;
    logic signed [bbs_pkg::VW-1:0]    mul_in, mul_out;
    logic signed [bbs_pkg::VEL_W-1:0] in_vx, in_vy, ld_vx, ld_vy;

    assign start    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    bbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .is_load  (s_tuser),
        .out_free (out_free),
        .ready    (s_tready),
        .ctl      (ctl)
    );

    // Feed the shared multiplier from the velocity the current step boosts
    assign mul_in = (ctl.wall_bottom || ctl.wall_top) ? vel_y_reg : vel_x_reg;

    bbs_boost_unit u_boost (
        .vel_in  (mul_in),
        .boost   (boost_reg),
        .negate  (!ctl.bottom_x),
        .vel_out (mul_out)
    );

    // Widen operands; unsigned quantities are zero extended
    assign x_ext  = CW'(pos_x_reg);
    assign y_ext  = CW'(pos_y_reg);
    assign vx_ext = CW'(vel_x_reg);
    assign vy_ext = CW'(vel_y_reg);
    assign g_ext  = {{(CW - bbs_pkg::GRAV_W){1'b0}}, gravity_reg};
    assign r_ext  = {{(CW - bbs_pkg::RAD_W - FRAC_BITS){1'b0}}, radius_reg,
                     {FRAC_BITS{1'b0}}};
    assign w_ext  = {{(CW - bbs_pkg::FIELD_W - FRAC_BITS){1'b0}}, width_reg,
                     {FRAC_BITS{1'b0}}};
    assign h_ext  = {{(CW - bbs_pkg::FIELD_W - FRAC_BITS){1'b0}}, height_reg,
                     {FRAC_BITS{1'b0}}};
    assign g_vel  = {{(bbs_pkg::VW - bbs_pkg::GRAV_W){1'b0}}, gravity_reg};

    // Gravity and motion
    assign sum_x = x_ext + vx_ext;
    assign sum_y = y_ext + vy_ext + g_ext;

    // Wall tests and clamp targets
    assign hit_right  = (x_ext + r_ext) > w_ext;
    assign hit_left   = x_ext < r_ext;
    assign hit_bottom = (y_ext + r_ext) > h_ext;
    assign hit_top    = y_ext < r_ext;
    assign clamp_r    = sat_pos(w_ext - r_ext);
    assign clamp_b    = sat_pos(h_ext - r_ext);
    assign clamp_lt   = sat_pos(r_ext);

    // Speed limit clamp
    assign lim_ext = {{(bbs_pkg::VW - bbs_pkg::LIM_W){1'b0}}, limit_reg};
    assign neg_lim = -lim_ext;
    assign vx_cl   = (vel_x_reg > lim_ext) ? lim_ext :
                     ((vel_x_reg < neg_lim) ? neg_lim : vel_x_reg);
    assign vy_cl   = (vel_y_reg > lim_ext) ? lim_ext :
                     ((vel_y_reg < neg_lim) ? neg_lim : vel_y_reg);

    // Loaded velocities: drop the one code outside the symmetric range
    assign in_vx = s_tdata[57:42];
    assign in_vy = s_tdata[73:58];
    assign ld_vx = (in_vx == bbs_pkg::VEL_RAW_MIN) ? bbs_pkg::VEL_NEG_MAX : in_vx;
    assign ld_vy = (in_vy == bbs_pkg::VEL_RAW_MIN) ? bbs_pkg::VEL_NEG_MAX : in_vy;

    // Ball state update, one step per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            vel_x_reg   <= '0;
            vel_y_reg   <= '0;
            bot_hit_reg <= 1'b0;
        end else begin
            if (ctl.load) begin
                pos_x_reg <= s_tdata[20:0];
                pos_y_reg <= s_tdata[41:21];
                vel_x_reg <= bbs_pkg::VW'(ld_vx);
                vel_y_reg <= bbs_pkg::VW'(ld_vy);
            end
            if (ctl.add) begin
                pos_x_reg   <= sat_pos(sum_x);
                pos_y_reg   <= sat_pos(sum_y);
                vel_y_reg   <= vel_y_reg + g_vel;
                bot_hit_reg <= 1'b0;
            end
            if (ctl.wall_right && hit_right) begin
                pos_x_reg <= clamp_r;
                vel_x_reg <= mul_out;
            end
            if (ctl.wall_left && hit_left) begin
                pos_x_reg <= clamp_lt;
                vel_x_reg <= mul_out;
            end
            if (ctl.wall_bottom && hit_bottom) begin
                pos_y_reg   <= clamp_b;
                vel_y_reg   <= mul_out;
                bot_hit_reg <= 1'b1;
            end
            if (ctl.bottom_x && bot_hit_reg) begin
                vel_x_reg <= mul_out;
            end
            if (ctl.wall_top && hit_top) begin
                pos_y_reg <= clamp_lt;
                vel_y_reg <= mul_out;
            end
            if (ctl.vel_clamp) begin
                vel_x_reg <= vx_cl;
                vel_y_reg <= vy_cl;
            end
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gravity_reg <= bbs_pkg::GRAV_W'(38);
            boost_reg   <= bbs_pkg::BOOST_W'(276);
            limit_reg   <= bbs_pkg::LIM_W'(7680);
            width_reg   <= bbs_pkg::FIELD_W'(800);
            height_reg  <= bbs_pkg::FIELD_W'(600);
            radius_reg  <= bbs_pkg::RAD_W'(20);
        end else if (cfg_we) begin
            unique case (cfg_index)
                bbs_pkg::CFG_GRAVITY_STEP: gravity_reg <= cfg_data[bbs_pkg::GRAV_W-1:0];
                bbs_pkg::CFG_BOOST_FACTOR: boost_reg   <= cfg_data[bbs_pkg::BOOST_W-1:0];
                bbs_pkg::CFG_SPEED_LIMIT:  limit_reg   <= cfg_data[bbs_pkg::LIM_W-1:0];
                bbs_pkg::CFG_FIELD_WIDTH:  width_reg   <= cfg_data[bbs_pkg::FIELD_W-1:0];
                bbs_pkg::CFG_FIELD_HEIGHT: height_reg  <= cfg_data[bbs_pkg::FIELD_W-1:0];
                bbs_pkg::CFG_RADIUS:       radius_reg  <= cfg_data[bbs_pkg::RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // Result register: hold until taken
    assign m_tdata_next = {{PAD_W{1'b0}}, vel_y_reg[bbs_pkg::VEL_W-1:0],
                           vel_x_reg[bbs_pkg::VEL_W-1:0], pos_y_reg, pos_x_reg};

    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctl.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `BBS_ASSERT_NOW(a_valid_from_out_step, aclk, aresetn, $rose(m_tvalid_reg), $past(ctl.out_load), "result raised without an output step")
    `BBS_ASSERT_NEXT(a_vel_within_limit, aclk, aresetn, ctl.vel_clamp, (vel_x_reg <= lim_ext) && (vel_x_reg >= neg_lim) && (vel_y_reg <= lim_ext) && (vel_y_reg >= neg_lim), "velocity outside speed limit after clamp")

endmodule

### tb/tb_bouncing_ball_step_core.sv
// Self-checking testbench for bouncing_ball_step_core: load and tick items over
// several register settings, checked against an in-bench ball predictor.
// Depends on bbs_pkg and the bouncing_ball_step_core RTL.
module tb_bouncing_ball_step_core;
    timeunit 1ns;
    timeprecision 1ps;

    // Widths and limits taken from the package
    localparam int POS_W      = bbs_pkg::POS_W;
    localparam int VEL_W      = bbs_pkg::VEL_W;
    localparam int GRAV_W     = bbs_pkg::GRAV_W;
    localparam int BOOST_W    = bbs_pkg::BOOST_W;
    localparam int LIM_W      = bbs_pkg::LIM_W;
    localparam int FIELD_W    = bbs_pkg::FIELD_W;
    localparam int RAD_W      = bbs_pkg::RAD_W;
    localparam int TDATA_W    = bbs_pkg::TDATA_W;
    localparam int CFG_IDX_W  = bbs_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = bbs_pkg::CFG_DATA_W;
    localparam int BOOST_BITS = bbs_pkg::BOOST_BITS;
    localparam int POS_MAX    = bbs_pkg::POS_MAX;
    localparam int POS_MIN    = bbs_pkg::POS_MIN;

    localparam int FRAC_BITS      = 8;
    localparam int STATE_W        = 2 * POS_W + 2 * VEL_W;
    localparam int PAD_W          = TDATA_W - STATE_W;
    localparam int VEL_LIMIT      = 32767;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 229;
    localparam int LONG_HOLD      = 600;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 5000;

    // tuser command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // Field layout of tdata, pos_x in the lowest bits
    typedef struct packed {
        logic signed [VEL_W-1:0] vel_y;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_x;
    } ball_state_t;

    typedef enum int { RX_ALWAYS, RX_RANDOM, RX_PERIODIC } rx_mode_t;

    // Predicts the ball state after each item and checks results in order
    class ball_scoreboard;
        logic [GRAV_W-1:0]  gravity_step;
        logic [BOOST_W-1:0] boost_factor;
        logic [LIM_W-1:0]   speed_limit;
        logic [FIELD_W-1:0] field_width;
        logic [FIELD_W-1:0] field_height;
        logic [RAD_W-1:0]   radius_px;
        longint             pos_x, pos_y, vel_x, vel_y;
        ball_state_t        expected_states[$];
        int                 errors;
        int                 checked;

        function new();
            gravity_step = 8'd38;
            boost_factor = 9'd276;
            speed_limit  = 15'd7680;
            field_width  = 12'd800;
            field_height = 12'd600;
            radius_px    = 8'd20;
            pos_x = 0;
            pos_y = 0;
            vel_x = 0;
            vel_y = 0;
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(bbs_pkg::bbs_cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                bbs_pkg::CFG_GRAVITY_STEP: gravity_step = value[GRAV_W-1:0];
                bbs_pkg::CFG_BOOST_FACTOR: boost_factor = value[BOOST_W-1:0];
                bbs_pkg::CFG_SPEED_LIMIT:  speed_limit  = value[LIM_W-1:0];
                bbs_pkg::CFG_FIELD_WIDTH:  field_width  = value[FIELD_W-1:0];
                bbs_pkg::CFG_FIELD_HEIGHT: field_height = value[FIELD_W-1:0];
                bbs_pkg::CFG_RADIUS:       radius_px    = value[RAD_W-1:0];
                default: ;
            endcase
        endfunction

        function longint limit_to(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        // Velocity times boost, optionally negated, floored by the shift
        function longint boosted(longint v, bit negate);
            longint p;
            p = v * longint'(boost_factor);
            if (negate) p = -p;
            return p >>> BOOST_BITS;
        endfunction

        function ball_state_t advance_ball(logic cmd, logic [TDATA_W-1:0] data);
            ball_state_t ld;
            ball_state_t st;
            longint r, w, h, lim, x, y, vx, vy;
            if (cmd == CMD_LOAD) begin
                ld = data[STATE_W-1:0];
                pos_x = longint'(ld.pos_x);
                pos_y = longint'(ld.pos_y);
                vel_x = limit_to(longint'(ld.vel_x), -VEL_LIMIT, VEL_LIMIT);
                vel_y = limit_to(longint'(ld.vel_y), -VEL_LIMIT, VEL_LIMIT);
            end else begin
                r   = longint'(radius_px) <<< FRAC_BITS;
                w   = longint'(field_width) <<< FRAC_BITS;
                h   = longint'(field_height) <<< FRAC_BITS;
                lim = longint'(speed_limit);
                // gravity, then move with saturation
                vx = vel_x;
                vy = vel_y + longint'(gravity_step);
                x = limit_to(pos_x + vx, POS_MIN, POS_MAX);
                y = limit_to(pos_y + vy, POS_MIN, POS_MAX);
                // walls in order: right, left, bottom, top
                if (x + r > w) begin
                    x = limit_to(w - r, POS_MIN, POS_MAX);
                    vx = boosted(vx, 1'b1);
                end
                if (x - r < 0) begin
                    x = limit_to(r, POS_MIN, POS_MAX);
                    vx = boosted(vx, 1'b1);
                end
                if (y + r > h) begin
                    y = limit_to(h - r, POS_MIN, POS_MAX);
                    vy = boosted(vy, 1'b1);
                    vx = boosted(vx, 1'b0);
                end
                if (y - r < 0) begin
                    y = limit_to(r, POS_MIN, POS_MAX);
                    vy = boosted(vy, 1'b1);
                end
                pos_x = x;
                pos_y = y;
                vel_x = limit_to(vx, -lim, lim);
                vel_y = limit_to(vy, -lim, lim);
            end
            st.pos_x = pos_x[POS_W-1:0];
            st.pos_y = pos_y[POS_W-1:0];
            st.vel_x = vel_x[VEL_W-1:0];
            st.vel_y = vel_y[VEL_W-1:0];
            return st;
        endfunction

        function void note_input(logic cmd, logic [TDATA_W-1:0] data);
            expected_states.push_back(advance_ball(cmd, data));
        endfunction

        function void flag_mismatch(string field, logic signed [31:0] want,
                                    logic signed [31:0] got);
            $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
            errors++;
        endfunction

        function void check_result(logic [TDATA_W-1:0] data);
            ball_state_t got;
            ball_state_t want;
            logic [PAD_W-1:0] pad;
            got = data[STATE_W-1:0];
            pad = data[TDATA_W-1:STATE_W];
            checked++;
            if (expected_states.size() == 0) begin
                $display("%0t ns: result %h arrived with no item pending", $time, data);
                errors++;
                return;
            end
            want = expected_states.pop_front();
            if (got.pos_x !== want.pos_x)
                flag_mismatch("pos_x", 32'(want.pos_x), 32'(got.pos_x));
            if (got.pos_y !== want.pos_y)
                flag_mismatch("pos_y", 32'(want.pos_y), 32'(got.pos_y));
            if (got.vel_x !== want.vel_x)
                flag_mismatch("vel_x", 32'(want.vel_x), 32'(got.vel_x));
            if (got.vel_y !== want.vel_y)
                flag_mismatch("vel_y", 32'(want.vel_y), 32'(got.vel_y));
            if (pad !== '0) flag_mismatch("pad", 0, 32'(pad));
        endfunction

        function int pending();
            return expected_states.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // load_pos_x, load_pos_y, load_vel_x, load_vel_y, zero pad (lowest first)
    logic [TDATA_W-1:0]    s_tdata = '0;
    // command
    logic                  s_tuser = CMD_TICK;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // pos_x, pos_y, vel_x, vel_y, zero pad (lowest first)
    logic [TDATA_W-1:0]    m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    ball_scoreboard board;
    bit hold_pending = 1'b0;
    int n_loads = 0;
    int n_ticks = 0;
    int n_settings = 0;

    bouncing_ball_step_core #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Offer one item and hold it until accepted
    task automatic send_item(logic cmd, logic [TDATA_W-1:0] data);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_input(cmd, data);
        if (cmd == CMD_LOAD) n_loads++;
        else n_ticks++;
    endtask

    task automatic send_load(int x, int y, int vx, int vy);
        ball_state_t st;
        st.pos_x = POS_W'(x);
        st.pos_y = POS_W'(y);
        st.vel_x = VEL_W'(vx);
        st.vel_y = VEL_W'(vy);
        send_item(CMD_LOAD, {{PAD_W{1'b0}}, st});
    endtask

    task automatic send_tick();
        send_item(CMD_TICK, '0);
    endtask

    // Drop valid and wait for every result plus the block's latency
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(bbs_pkg::bbs_cfg_idx_t idx, int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge aclk);
        board.write_reg(idx, value[CFG_DATA_W-1:0]);
    endtask

    task automatic apply_settings(int grav, int boost, int lim, int w, int h, int rad);
        write_register(bbs_pkg::CFG_GRAVITY_STEP, grav);
        write_register(bbs_pkg::CFG_BOOST_FACTOR, boost);
        write_register(bbs_pkg::CFG_SPEED_LIMIT, lim);
        write_register(bbs_pkg::CFG_FIELD_WIDTH, w);
        write_register(bbs_pkg::CFG_FIELD_HEIGHT, h);
        write_register(bbs_pkg::CFG_RADIUS, rad);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Mostly typical values, with each extreme now and then
    function automatic int pick_value(int lo, int hi);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return lo;
        if (r == 1) return hi;
        return $urandom_range(lo, hi);
    endfunction

    // Load item: mostly a ball inside the current field, sometimes raw noise
    function automatic logic [TDATA_W-1:0] make_load_item();
        ball_state_t st;
        logic [95:0] raw;
        int span_x, span_y, vmax, x, y;
        if ($urandom_range(0, 3) == 0) begin
            raw = {$urandom(), $urandom(), $urandom()};
            st = raw[STATE_W-1:0];
        end else begin
            span_x = (int'(board.field_width) + int'(board.radius_px) + 8) * 256;
            span_y = (int'(board.field_height) + int'(board.radius_px) + 8) * 256;
            vmax = int'(board.speed_limit) + 512;
            if (vmax > VEL_LIMIT) vmax = VEL_LIMIT;
            x = int'($urandom_range(0, span_x + 4096)) - 2048;
            y = int'($urandom_range(0, span_y + 4096)) - 2048;
            if (x > POS_MAX) x = POS_MAX;
            if (y > POS_MAX) y = POS_MAX;
            st.pos_x = POS_W'(x);
            st.pos_y = POS_W'(y);
            st.vel_x = VEL_W'(int'($urandom_range(0, 2 * vmax)) - vmax);
            st.vel_y = VEL_W'(int'($urandom_range(0, 2 * vmax)) - vmax);
        end
        return {{PAD_W{1'b0}}, st};
    endfunction

    // Random bursts of load-then-ticks sequences; optionally a long receiver hold
    task automatic run_random_phase(int n_items, bit with_hold);
        int sent, burst_left, run_left, gap;
        logic cmd;
        logic [TDATA_W-1:0] data;
        logic [95:0] raw;
        burst_left = $urandom_range(1, 16);
        run_left = 0;
        for (sent = 0; sent < n_items; sent++) begin
            if (with_hold && sent == 40) begin
                hold_pending = 1'b1;
                burst_left = 120;
            end
            if (run_left == 0) begin
                cmd = CMD_LOAD;
                run_left = $urandom_range(3, 40);
            end else begin
                run_left--;
                cmd = ($urandom_range(0, 19) == 0) ? CMD_LOAD : CMD_TICK;
            end
            if (cmd == CMD_LOAD) begin
                data = make_load_item();
            end else begin
                raw = {$urandom(), $urandom(), $urandom()};
                data = {{PAD_W{1'b0}}, raw[STATE_W-1:0]};
            end
            send_item(cmd, data);
            burst_left--;
            if (burst_left == 0) begin
                gap = $urandom_range(0, 9);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 100)
                                                         : $urandom_range(1, 16);
            end
        end
        wait_for_drain();
    endtask

    // Check every accepted result
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
    end

    // Receiver: always-ready, random or periodic stall patterns, re-picked at random, plus the long hold
    initial begin : receiver
        rx_mode_t rx_mode;
        int rx_count;
        rx_mode = RX_ALWAYS;
        rx_count = 0;
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                if (rx_count % 300 == 0) rx_mode = rx_mode_t'($urandom_range(0, 2));
                case (rx_mode)
                    RX_ALWAYS: m_tready <= 1'b1;
                    RX_RANDOM: m_tready <= ($urandom_range(0, 9) > 2);
                    default:   m_tready <= ((rx_count % 11) < 6);
                endcase
                rx_count++;
                @(posedge aclk);
            end
        end
    end

    // Stop the run if no handshake happens for too long
    initial begin : watchdog
        int idle_run;
        idle_run = 0;
        while (idle_run < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_run = 0;
            else idle_run++;
        end
        $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        int phase;
        board = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: first tick from the zero state, then each wall and the extremes
        send_tick();
        send_load(POS_MAX, POS_MAX, 32767, 32767);
        send_tick();
        send_load(POS_MIN, POS_MIN, -32768, -32768);
        send_tick();
        send_load(400 * 256, 590 * 256, 1000, 3000);
        send_tick();
        send_load(400 * 256, 10 * 256, -500, -3000);
        send_tick();
        send_load(790 * 256, 300 * 256, 2000, 0);
        send_tick();
        send_load(5 * 256, 300 * 256, -2000, 0);
        send_tick();
        send_load(400 * 256, 300 * 256, 100, 30000);
        send_tick();
        wait_for_drain();

        // Radius beyond the walls, zero height, top gains and limit
        apply_settings(255, 511, 32767, 100, 0, 255);
        send_load(50 * 256, 50 * 256, 32767, -32767);
        send_tick();
        send_tick();
        wait_for_drain();

        // Zero gravity, boost and speed limit in a huge field
        apply_settings(0, 0, 0, 4095, 4095, 0);
        send_load(2000 * 256, 2000 * 256, -1234, 4321);
        send_tick();
        wait_for_drain();

        // Zero width
        apply_settings(128, 256, 1000, 0, 4095, 1);
        send_load(0, 0, 5, 5);
        send_tick();
        wait_for_drain();

        // Random phases: nominal settings, all-high settings, then random ones
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0) apply_settings(38, 276, 7680, 800, 600, 20);
            else if (phase == 1) apply_settings(255, 511, 32767, 4095, 4095, 255);
            else apply_settings(pick_value(0, 255), pick_value(0, 511),
                                pick_value(0, 32767), pick_value(0, 4095),
                                pick_value(0, 4095), pick_value(0, 255));
            run_random_phase(PHASE_ITEMS, phase == 2);
        end

        if (board.pending() != 0) begin
            $display("%0t ns: %0d results never arrived", $time, board.pending());
            board.errors += board.pending();
        end
        $display("Ran %0d items (%0d loads, %0d ticks) across %0d register settings",
                 n_loads + n_ticks, n_loads, n_ticks, n_settings);
        $display("Checked %0d results, %0d mismatches", board.checked, board.errors);
        if (board.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### bouncing_ball_step_core.f
+incdir+hdl
hdl/bbs_pkg.sv
hdl/bbs_boost_unit.sv
hdl/bbs_ctrl.sv
hdl/bouncing_ball_step_core.sv
tb/tb_bouncing_ball_step_core.sv
